>>> sv/ncr_pkg.sv
// Package for the numeric character reference decoder.
// Holds the result codes, the token form type, character constants and the result packet.
// No dependencies.
package ncr_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SYNTAX  = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    // Largest Unicode scalar value.
    localparam logic [20:0] CP_MAX = 21'h10FFFF;

    // Characters with a special meaning in a reference token.
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_UPPER_X = 8'h58;

    // Form of the token, learned from its first two bytes.
    typedef enum logic [1:0] {
        FORM_UNKNOWN = 2'd0,
        FORM_HEX     = 2'd1,
        FORM_DEC     = 2'd2,
        FORM_OTHER   = 2'd3
    } form_t;

    // All results caused by one input beat: up to four bytes that share
    // status and consumed count.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      count;
        logic [1:0]      status;
        logic [5:0]      consumed;
    } ncr_pkt_t;

endpackage

>>> sv/ncr_accum.sv
// Token state and decode logic of the numeric character reference decoder.
// Updates the token count, form and code point accumulator for each input beat
// and builds the result packet. Depends on ncr_pkg.
module ncr_accum #(
    parameter int MAX_TOKEN_LEN = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            end_of_data,
    output ncr_pkg::ncr_pkt_t pkt
);
    import ncr_pkg::*;

    logic [5:0]  count_reg, count_next;
    form_t       form_reg, form_next;
    logic [20:0] cp_reg, cp_next;
    logic        ovf_reg, ovf_next;
    logic        done_reg, done_next;

    logic        is_dec;
    logic        is_lower;
    logic        is_upper;
    logic        is_alnum;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic        do_add;
    logic        base16;
    logic [3:0]  digit;
    logic [24:0] mac_sum;
    logic [20:0] cp_fin;
    logic [5:0]  cons;
    logic [1:0]  fin_status;

    // Character classes of the incoming byte.
    always_comb
    begin
        is_dec   = (in_byte >= 8'h30) && (in_byte <= 8'h39);
        is_lower = (in_byte >= 8'h61) && (in_byte <= 8'h7A);
        is_upper = (in_byte >= 8'h41) && (in_byte <= 8'h5A);
        is_alnum = is_dec || is_lower || is_upper;
        hex_ok   = 1'b1;
        hex_val  = in_byte[3:0];
        if (is_dec) begin
            hex_val = in_byte[3:0];
        end else if (((in_byte >= 8'h61) && (in_byte <= 8'h66)) ||
                     ((in_byte >= 8'h41) && (in_byte <= 8'h46))) begin
            hex_val = in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    // One multiply-accumulate step: times 16 or times 10, plus the digit.
    always_comb
    begin
        if (base16) begin
            mac_sum = {cp_reg, 4'b0000} + {21'd0, digit};
        end else begin
            mac_sum = {1'b0, cp_reg, 3'b000} + {3'b000, cp_reg, 1'b0} + {21'd0, digit};
        end
    end

    // Values that a terminating semicolon reports.
    always_comb
    begin
        cp_fin     = ovf_reg ? CP_MAX : cp_reg;
        fin_status = ovf_reg ? ST_NOMATCH : ST_OK;
        cons       = (count_reg == 6'd63) ? 6'd63 : count_reg + 6'd1;
    end

    // Next state and result packet for the current beat.
    always_comb
    begin
        count_next = count_reg;
        form_next  = form_reg;
        cp_next    = cp_reg;
        ovf_next   = ovf_reg;
        done_next  = done_reg;
        do_add     = 1'b0;
        base16     = 1'b0;
        digit      = in_byte[3:0];

        pkt.data     = '0;
        pkt.count    = 3'd0;
        pkt.status   = ST_OK;
        pkt.consumed = 6'd0;

        if (in_byte == CH_SEMI) begin
            // End of token: encode the code point or report no match.
            count_next = 6'd0;
            form_next  = FORM_UNKNOWN;
            cp_next    = '0;
            ovf_next   = 1'b0;
            done_next  = 1'b0;
            if ((count_reg < 6'd2) || ((form_reg != FORM_HEX) && (form_reg != FORM_DEC))) begin
                pkt.count  = 3'd1;
                pkt.status = ST_NOMATCH;
            end else begin
                pkt.status   = fin_status;
                pkt.consumed = cons;
                if (cp_fin < 21'h80) begin
                    pkt.data[0] = cp_fin[7:0];
                    pkt.count   = 3'd1;
                end else if (cp_fin < 21'h800) begin
                    pkt.data[0] = {3'b110, cp_fin[10:6]};
                    pkt.data[1] = {2'b10, cp_fin[5:0]};
                    pkt.count   = 3'd2;
                end else if (cp_fin < 21'h10000) begin
                    pkt.data[0] = {4'b1110, cp_fin[15:12]};
                    pkt.data[1] = {2'b10, cp_fin[11:6]};
                    pkt.data[2] = {2'b10, cp_fin[5:0]};
                    pkt.count   = 3'd3;
                end else begin
                    pkt.data[0] = {5'b11110, cp_fin[20:18]};
                    pkt.data[1] = {2'b10, cp_fin[17:12]};
                    pkt.data[2] = {2'b10, cp_fin[11:6]};
                    pkt.data[3] = {2'b10, cp_fin[5:0]};
                    pkt.count   = 3'd4;
                end
            end
        end else if (!is_alnum || end_of_data || (count_reg >= 6'(MAX_TOKEN_LEN))) begin
            // Bad byte, missing semicolon or token too long.
            count_next = 6'd0;
            form_next  = FORM_UNKNOWN;
            cp_next    = '0;
            ovf_next   = 1'b0;
            done_next  = 1'b0;
            pkt.count  = 3'd1;
            pkt.status = ST_SYNTAX;
        end else begin
            count_next = count_reg + 6'd1;
            if (count_reg == 6'd0) begin
                // The first byte sets the form.
                if ((in_byte == CH_LOWER_X) || (in_byte == CH_UPPER_X)) begin
                    form_next = FORM_HEX;
                end else if (is_dec) begin
                    form_next = FORM_DEC;
                    do_add    = 1'b1;
                end else begin
                    form_next = FORM_OTHER;
                end
            end else if (form_reg == FORM_HEX) begin
                base16 = 1'b1;
                digit  = hex_val;
                if ((count_reg == 6'd1) && !hex_ok) begin
                    form_next = FORM_OTHER;
                end else if (!done_reg) begin
                    if (!hex_ok) begin
                        done_next = 1'b1;
                    end else begin
                        do_add = 1'b1;
                    end
                end
            end else if ((form_reg == FORM_DEC) && !done_reg) begin
                if (is_dec) begin
                    do_add = 1'b1;
                end else begin
                    done_next = 1'b1;
                end
            end

            // Accumulate, saturating past the largest code point.
            if (do_add && !ovf_reg) begin
                if (mac_sum > {4'd0, CP_MAX}) begin
                    ovf_next = 1'b1;
                    cp_next  = CP_MAX;
                end else begin
                    cp_next = mac_sum[20:0];
                end
            end
        end
    end

    // Token state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 6'd0;
            form_reg  <= FORM_UNKNOWN;
            cp_reg    <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end else if (accept) begin
            count_reg <= count_next;
            form_reg  <= form_next;
            cp_reg    <= cp_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

endmodule

>>> sv/ncr_emit.sv
// Result register and byte serializer of the numeric character reference decoder.
// Holds the packet of one input beat and hands out its bytes one beat at a time.
// Depends on ncr_pkg.
module ncr_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  ncr_pkg::ncr_pkt_t pkt,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              last_byte,
    output logic [1:0]        status,
    output logic [5:0]        consumed
);
    import ncr_pkg::*;

    logic [3:0][7:0] data_reg, data_next;
    logic [2:0]      left_reg, left_next;
    logic [1:0]      status_reg, status_next;
    logic [5:0]      cons_reg, cons_next;
    logic            out_fire;

    // The register takes a new packet once it is empty or its final beat leaves now.
    assign out_fire  = out_valid && out_ready;
    assign can_load  = (left_reg == 3'd0) || ((left_reg == 3'd1) && out_ready);
    assign out_valid = (left_reg != 3'd0);
    assign out_byte  = data_reg[0];
    assign last_byte = (left_reg == 3'd1);
    assign status    = status_reg;
    assign consumed  = cons_reg;

    // Load a packet that carries results, otherwise shift out on each output beat.
    always_comb
    begin
        data_next   = data_reg;
        left_next   = left_reg;
        status_next = status_reg;
        cons_next   = cons_reg;
        if (load && (pkt.count != 3'd0)) begin
            data_next   = pkt.data;
            left_next   = pkt.count;
            status_next = pkt.status;
            cons_next   = pkt.consumed;
        end else if (out_fire) begin
            data_next = {8'd0, data_reg[3:1]};
            left_next = left_reg - 3'd1;
        end
    end

    // Control count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            left_reg <= 3'd0;
        end else begin
            left_reg <= left_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        status_reg <= status_next;
        cons_reg   <= cons_next;
    end

endmodule

>>> sv/numeric_char_reference_to_utf8.sv
// Numeric character reference decoder, top level: takes the bytes after an ampersand
// and returns the UTF-8 bytes of the referenced character. Depends on ncr_pkg,
// ncr_accum and ncr_emit.
//
// One input beat can be taken in every cycle in which in_ready is high. A beat that ends
// a token loads one to four result beats into the result register, and they leave one per
// cycle while out_ready is high, starting in the cycle after that beat is taken. While
// more than the final byte of that packet is still waiting, in_ready is low for every
// input beat, including bytes inside a token that produce no result. A reference that
// decodes to more than one byte therefore holds the input after its semicolon until its
// final byte is leaving, and output back-pressure makes that hold longer. The token state is
// updated by one multiply-accumulate step per beat, and the UTF-8 encoding is done
// from the stored code point when the semicolon arrives.
module numeric_char_reference_to_utf8 #(
    parameter int MAX_TOKEN_LEN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_byte,
    output logic [1:0] status,
    output logic [5:0] consumed
);
    import ncr_pkg::*;

    ncr_pkt_t pkt;
    logic     accept;

    // An input beat is accepted whenever the result register can take its packet.
    assign accept = in_valid && in_ready;

    ncr_accum #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .end_of_data (end_of_data),
        .pkt         (pkt)
    );

    ncr_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .pkt       (pkt),
        .can_load  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte),
        .status    (status),
        .consumed  (consumed)
    );

endmodule
